@@ rtl/core/crfm_pkg.sv @@
// ----------------------------------------------------------------------------
// crfm_pkg: shared definitions for the CAN receive filter and mailboxes
// Command codes, filter kinds and the stored filter entry layout.
// ----------------------------------------------------------------------------
package crfm_pkg;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] KIND_ID_ONLY  = 2'd0;
	localparam logic [1:0] KIND_ID_B0    = 2'd1;
	localparam logic [1:0] KIND_ID_B0_B1 = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	// Width used for entry counts and slot range checks; it holds any
	// count up to the largest supported number of slots.
	localparam int CNT_W = 7;

	typedef struct packed {
		logic [28:0] ident;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
	} filt_entry_t;

endpackage

@@ rtl/core/crfm_entry_cmp.sv @@
// ----------------------------------------------------------------------------
// crfm_entry_cmp: filter entry comparator
// Decides whether one filter entry accepts a frame's identifier and bytes.
// ----------------------------------------------------------------------------
module crfm_entry_cmp (
	input  crfm_pkg::filt_entry_t entry,
	input  logic [1:0]            kind,
	input  logic [28:0]           can_id,
	input  logic [15:0]           head_bytes,
	output logic                  hit
);
	import crfm_pkg::*;

	logic id_eq;
	logic b0_eq;
	logic b1_eq;

	assign id_eq = (entry.ident == can_id);
	assign b0_eq = (entry.first_byte == head_bytes[7:0]);
	assign b1_eq = (entry.second_byte == head_bytes[15:8]);

	always_comb begin
		unique case (kind)
			KIND_ID_ONLY:  hit = id_eq;
			KIND_ID_B0:    hit = id_eq && b0_eq;
			KIND_ID_B0_B1: hit = id_eq && b0_eq && b1_eq;
			default:       hit = 1'b0;
		endcase
	end

endmodule

@@ rtl/core/can_rx_filter_mailbox.sv @@
// ----------------------------------------------------------------------------
// can_rx_filter_mailbox: CAN receive acceptance filter with mailboxes
// Walks the filter table entry by entry with one shared comparator and keeps
// one mailbox of eight data bytes per filter entry.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the input channel (in_valid / in_stall) and each
// one yields exactly one result on the output channel (out_valid /
// out_stall). A request is taken when in_valid is high and in_stall is low.
// Command 0 presents a received frame, command 1 reads a mailbox and clears
// its fresh flag, command 2 loads a filter entry, command 3 does nothing.
// The user must write the entry_count register through cfg_write / cfg_data
// only while the block is idle; the block itself does not enforce this.
// Sequence. A frame is taken, then the filter entries are inspected one at a
// time (stopping at the first match, at most the active entry count), and
// the result is handed to the output register. A read first fetches its
// mailbox; a load or a no-op hands its result on directly. The single
// comparator steps through the filter memory one entry a cycle.
// in_stall is high from the cycle after a request is taken until its result
// has been placed in the output register.
// Stalling. The output register holds its result while out_stall is high; a
// new request may still be taken and worked on, and its result waits in the
// sequencer until the output register is free.
// Reset. All filter entries become unused, mailboxes read as zero, fresh
// flags clear and entry_count is zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module can_rx_filter_mailbox #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [4:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [28:0] can_id,
	input  logic [63:0] payload,
	input  logic [3:0]  slot,
	input  logic [1:0]  match_kind,
	input  logic [7:0]  match_byte1,
	input  logic [7:0]  match_byte2,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [3:0]  matched_slot,
	output logic        slot_valid,
	output logic        was_fresh,
	output logic [63:0] slot_payload
);
	import crfm_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_READ,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [4:0]       entry_count_q;
	logic [CNT_W-1:0] active_w;

	// Request held for the duration of its work.
	logic [28:0]      id_q;
	logic [63:0]      pay_q;
	logic [3:0]       slot_q;
	logic [IW-1:0]    idx_q;

	// Result being assembled by the sequencer.
	logic             res_matched_q;
	logic [3:0]       res_mslot_q;
	logic             res_valid_q;
	logic             res_fresh_q;
	logic [63:0]      res_payload_q;

	// Output register.
	logic             out_valid_q;
	logic             out_matched_q;
	logic [3:0]       out_mslot_q;
	logic             out_slot_valid_q;
	logic             out_fresh_q;
	logic [63:0]      out_payload_q;

	// Per-slot flags and kinds, cleared by reset.
	logic [1:0]       kind_q [SLOTS];
	logic [SLOTS-1:0] fresh_q;
	logic [SLOTS-1:0] written_q;

	// Filter and mailbox memories, registered reads.
	filt_entry_t      filt_mem [SLOTS];
	filt_entry_t      filt_rd_q;
	logic [63:0]      mb_mem [SLOTS];
	logic [63:0]      mb_rd_q;

	logic             in_accept;
	logic [IW-1:0]    slot_idx_in;
	logic [IW-1:0]    slot_idx_q;
	logic             read_in_range;
	logic             load_in_range;
	logic             walk_last;
	logic             hit;
	logic [IW-1:0]    filt_raddr;
	logic             filt_we;
	logic             mb_we;
	logic             out_free;

	// An entry count above the number of slots behaves as the slot count.
	assign active_w = (CNT_W'(entry_count_q) > CNT_W'(SLOTS)) ?
		CNT_W'(SLOTS) : CNT_W'(entry_count_q);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign slot_idx_in   = IW'(slot);
	assign slot_idx_q    = IW'(slot_q);
	assign read_in_range = (CNT_W'(slot) < active_w);
	// A load is allowed into any existing slot, enabled or not.
	assign load_in_range = (CNT_W'(slot) < CNT_W'(SLOTS));
	assign walk_last     = ((CNT_W'(idx_q) + CNT_W'(1)) == active_w);

	// The filter read address runs one entry ahead of the comparator, so
	// that the registered read data always belongs to idx_q during the walk.
	always_comb begin
		if (state_q == ST_IDLE) begin
			filt_raddr = '0;
		end else if (idx_q == IW'(SLOTS - 1)) begin
			filt_raddr = '0;
		end else begin
			filt_raddr = idx_q + 1'b1;
		end
	end

	assign filt_we  = in_accept && (command == CMD_LOAD) && load_in_range;
	assign mb_we    = (state_q == ST_WALK) && hit;
	assign out_free = !out_valid_q || !out_stall;

	crfm_entry_cmp u_cmp (
		.entry      (filt_rd_q),
		.kind       (kind_q[idx_q]),
		.can_id     (id_q),
		.head_bytes (pay_q[15:0]),
		.hit        (hit)
	);

	always_ff @(posedge clk) begin
		if (filt_we) begin
			filt_mem[slot_idx_in] <= '{ident: can_id, first_byte: match_byte1,
				second_byte: match_byte2};
		end
		filt_rd_q <= filt_mem[filt_raddr];
	end

	always_ff @(posedge clk) begin
		if (mb_we) begin
			mb_mem[idx_q] <= pay_q;
		end
		mb_rd_q <= mb_mem[slot_idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			entry_count_q    <= '0;
			id_q             <= '0;
			pay_q            <= '0;
			slot_q           <= '0;
			idx_q            <= '0;
			res_matched_q    <= 1'b0;
			res_mslot_q      <= '0;
			res_valid_q      <= 1'b0;
			res_fresh_q      <= 1'b0;
			res_payload_q    <= '0;
			out_valid_q      <= 1'b0;
			out_matched_q    <= 1'b0;
			out_mslot_q      <= '0;
			out_slot_valid_q <= 1'b0;
			out_fresh_q      <= 1'b0;
			out_payload_q    <= '0;
			fresh_q          <= '0;
			written_q        <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i] <= KIND_UNUSED;
			end
		end else begin
			if (cfg_write) begin
				entry_count_q <= cfg_data;
			end
			// In ST_FIN the output register is reloaded below instead.
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						id_q          <= can_id;
						pay_q         <= payload;
						slot_q        <= slot;
						idx_q         <= '0;
						res_matched_q <= 1'b0;
						res_mslot_q   <= '0;
						res_valid_q   <= 1'b0;
						res_fresh_q   <= 1'b0;
						res_payload_q <= '0;
						unique case (command)
							CMD_FRAME: begin
								state_q <= (active_w == '0) ? ST_FIN : ST_WALK;
							end
							CMD_READ: begin
								state_q <= read_in_range ? ST_READ : ST_FIN;
							end
							CMD_LOAD: begin
								if (load_in_range) begin
									kind_q[slot_idx_in] <= match_kind;
									res_valid_q         <= 1'b1;
								end
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (hit) begin
						fresh_q[idx_q]   <= 1'b1;
						written_q[idx_q] <= 1'b1;
						res_matched_q    <= 1'b1;
						res_mslot_q      <= 4'(idx_q);
						state_q          <= ST_FIN;
					end else if (walk_last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_READ: begin
					res_valid_q         <= 1'b1;
					res_fresh_q         <= fresh_q[slot_idx_q];
					// A mailbox never filled reads as zero.
					res_payload_q       <= written_q[slot_idx_q] ? mb_rd_q : '0;
					fresh_q[slot_idx_q] <= 1'b0;
					state_q             <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_matched_q    <= res_matched_q;
						out_mslot_q      <= res_mslot_q;
						out_slot_valid_q <= res_valid_q;
						out_fresh_q      <= res_fresh_q;
						out_payload_q    <= res_payload_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign matched      = out_matched_q;
	assign matched_slot = out_mslot_q;
	assign slot_valid   = out_slot_valid_q;
	assign was_fresh    = out_fresh_q;
	assign slot_payload = out_payload_q;

`ifndef SYNTHESIS
	// The walk never inspects an entry at or beyond the active count.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CNT_W'(idx_q) < active_w))
		else $error("filter walk beyond active entries");

	// A mailbox can only be fresh once it has been written.
	a_fresh_written: assert property (@(posedge clk) disable iff (!arst_n)
		((fresh_q & ~written_q) == '0))
		else $error("fresh flag set on a mailbox never written");

	// A taken request always starts work in the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q != ST_IDLE))
		else $error("request taken but sequencer stayed idle");

	// Frame results and slot results never appear together.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_matched_q && out_slot_valid_q))
		else $error("result marks both a match and a valid slot");
`endif

endmodule
